// ----- rtl/elevation_to_light_color_top_assert.svh -----
// Assertion macros used by the top-level RTL.
`ifndef ELEVATION_TO_LIGHT_COLOR_TOP_ASSERT_SVH
`define ELEVATION_TO_LIGHT_COLOR_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ELC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("elc assertion failed");

// Next-cycle implication, checked outside reset.
`define ELC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("elc assertion failed");

`endif

// ----- rtl/elc_pkg.sv -----
`timescale 1ns / 1ps
package elc_pkg;

  localparam int ELEV_W      = 11;
  localparam int LVL_W       = 8;
  localparam int KELV_W      = 13;
  localparam int X_W         = 8;
  localparam int NK_W        = 17;
  localparam int NB_W        = 12;
  localparam int QK_W        = 10;
  localparam int QB_W        = 6;
  localparam int SPANK_W     = 10;
  localparam int SPANB_W     = 6;
  localparam int DIV_W       = 8;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SH    = 18;
  localparam int MK_W        = NK_W + RECIP_W;
  localparam int MB_W        = NB_W + RECIP_W;
  localparam int ROM_DEPTH   = 5001;
  localparam int ROM_IDX_W   = 13;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;

  localparam logic [KELV_W-1:0] KELV_MIN      = 13'd1500;
  localparam logic [KELV_W-1:0] KELV_MAX      = 13'd6500;
  localparam logic [KELV_W-1:0] KELV_BLUE_MIN = 13'd1900;
  localparam logic [LVL_W-1:0]  LVL_FULL      = 8'd255;

  // Curve constants, unsigned Q24
  localparam logic [63:0] Q24_ONE = 64'd16777216;
  localparam logic [63:0] DEC_ONE = 64'd10000000000;
  localparam logic [63:0] G_COEF  = 64'd99 * Q24_ONE + (64'd4708025861 * Q24_ONE) / DEC_ONE;
  localparam logic [63:0] G_OFFS  = 64'd161 * Q24_ONE + (64'd1195681661 * Q24_ONE) / DEC_ONE;
  localparam logic [63:0] B_COEF  = 64'd138 * Q24_ONE + (64'd5177312231 * Q24_ONE) / DEC_ONE;
  localparam logic [63:0] B_OFFS  = 64'd305 * Q24_ONE + (64'd447927307 * Q24_ONE) / DEC_ONE;

  typedef enum logic [3:0] {
    BAND_NIGHT,
    BAND_ASTRO,
    BAND_NAUT,
    BAND_CIVIL,
    BAND_LOW,
    BAND_MORNING,
    BAND_MID,
    BAND_HIGH,
    BAND_TOP
  } band_t;

  typedef struct packed {
    logic signed [ELEV_W-1:0] lo;
    logic [KELV_W-1:0]        kbase;
    logic [SPANK_W-1:0]       kspan;
    logic [LVL_W-1:0]         bbase;
    logic [SPANB_W-1:0]       bspan;
    logic [DIV_W-1:0]         div;
    logic [RECIP_W-1:0]       recip;
  } band_const_t;

  typedef struct packed {
    band_t          band;
    logic [X_W-1:0] x;
  } sel_t;

  typedef struct packed {
    band_t           band;
    logic [NK_W-1:0] nk;
    logic [NB_W-1:0] nb;
  } prod_t;

  typedef struct packed {
    band_t           band;
    logic [NK_W-1:0] nk;
    logic [NB_W-1:0] nb;
    logic [QK_W-1:0] qk;
    logic [QB_W-1:0] qb;
  } quot_t;

  typedef struct packed {
    logic              night;
    logic [KELV_W-1:0] kelvin;
    logic [LVL_W-1:0]  brightness;
  } light_t;

  typedef struct packed {
    logic [KELV_W-1:0] color_kelvin;
    logic [LVL_W-1:0]  brightness;
    logic [LVL_W-1:0]  blue;
    logic [LVL_W-1:0]  green;
    logic [LVL_W-1:0]  red;
  } color_t;

  typedef logic [2*LVL_W-1:0] rom_word_t;
  typedef rom_word_t rom_t [0:ROM_DEPTH-1];

  function automatic band_const_t band_const(band_t b);
    band_const_t c;
    unique case (b)
      BAND_ASTRO:   c = '{-11'sd180, 13'd1500, 10'd0,    8'd0,   6'd40, 8'd60,  13'd4369};
      BAND_NAUT:    c = '{-11'sd120, 13'd1500, 10'd500,  8'd40,  6'd40, 8'd60,  13'd4369};
      BAND_CIVIL:   c = '{-11'sd60,  13'd2000, 10'd800,  8'd80,  6'd60, 8'd52,  13'd5041};
      BAND_LOW:     c = '{-11'sd8,   13'd2800, 10'd1000, 8'd140, 6'd60, 8'd68,  13'd3855};
      BAND_MORNING: c = '{11'sd60,   13'd3800, 10'd1000, 8'd200, 6'd30, 8'd90,  13'd2912};
      BAND_MID:     c = '{11'sd150,  13'd4800, 10'd700,  8'd230, 6'd20, 8'd150, 13'd1747};
      BAND_HIGH:    c = '{11'sd300,  13'd5500, 10'd400,  8'd255, 6'd0,  8'd200, 13'd1310};
      BAND_TOP:     c = '{11'sd500,  13'd6500, 10'd0,    8'd255, 6'd0,  8'd1,   13'd0};
      default:      c = '{11'sd0,    13'd0,    10'd0,    8'd0,   6'd0,  8'd1,   13'd0};
    endcase
    return c;
  endfunction

  function automatic band_t band_of(logic signed [ELEV_W-1:0] t);
    band_t b;
    if (t < -11'sd180)      b = BAND_NIGHT;
    else if (t < -11'sd120) b = BAND_ASTRO;
    else if (t < -11'sd60)  b = BAND_NAUT;
    else if (t < -11'sd8)   b = BAND_CIVIL;
    else if (t < 11'sd60)   b = BAND_LOW;
    else if (t < 11'sd150)  b = BAND_MORNING;
    else if (t < 11'sd300)  b = BAND_MID;
    else if (t < 11'sd500)  b = BAND_HIGH;
    else                    b = BAND_TOP;
    return b;
  endfunction

  // Shift-subtract quotient, used only while building the color ROM
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] atanh_q30(logic [63:0] z);
    logic [63:0] sum;
    logic [63:0] p;
    logic [63:0] z2;
    logic        done;
    sum  = z;
    p    = z;
    z2   = (z * z) >> 30;
    done = 1'b0;
    for (int k = 3; k < 99; k += 2) begin
      if (!done) begin
        p = (p * z2) >> 30;
        if (p == 64'd0) done = 1'b1;
        else            sum  = sum + udiv64(p, 64'(k));
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] ln_q30(logic [31:0] x, logic [63:0] ln2);
    int          n;
    logic [63:0] base;
    logic [63:0] z;
    n = 0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) n = i;
    end
    base = 64'd1 << n;
    z    = udiv64((64'(x) - base) << 30, 64'(x) + base);
    return (x == 32'd0) ? 64'd0 : 64'(n) * ln2 + 64'd2 * atanh_q30(z);
  endfunction

  function automatic logic [LVL_W-1:0] log_level(logic [63:0] coef, logic [63:0] offs,
                                                 logic [31:0] num, logic [63:0] ln2,
                                                 logic [63:0] ln100);
    logic [63:0] ln_num;
    logic [63:0] lnv;
    logic [63:0] prod;
    logic [63:0] v;
    ln_num = ln_q30(num, ln2);
    lnv    = (ln_num > ln100) ? ln_num - ln100 : 64'd0;
    prod   = (coef * lnv) >> 30;
    v      = (prod > offs) ? (prod - offs) >> 24 : 64'd0;
    return (v > 64'(LVL_FULL)) ? LVL_FULL : v[LVL_W-1:0];
  endfunction

  // Fill every kelvin value the band maps can reach; others stay zero
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] ln2;
    logic [63:0] ln100;
    band_const_t c;
    int          x;
    int          nk;
    int          q;
    int          k;
    logic [LVL_W-1:0] g;
    logic [LVL_W-1:0] bl;
    rom   = '{default: '0};
    ln2   = 64'd2 * atanh_q30(udiv64(64'd1 << 30, 64'd3));
    ln100 = ln_q30(32'd100, ln2);
    for (int t = -180; t <= 500; t++) begin
      c  = band_const(band_of(ELEV_W'(t)));
      x  = t - int'(c.lo);
      nk = x * int'(c.kspan);
      q  = (nk * int'(c.recip)) >>> RECIP_SH;
      if (nk - q * int'(c.div) >= int'(c.div)) q = q + 1;
      k  = int'(c.kbase) + q;
      g  = log_level(G_COEF, G_OFFS, 32'(k), ln2, ln100);
      bl = (k <= int'(KELV_BLUE_MIN)) ? '0 :
           log_level(B_COEF, B_OFFS, 32'(k - 1000), ln2, ln100);
      rom[k - int'(KELV_MIN)] = {g, bl};
    end
    return rom;
  endfunction

endpackage

// ----- rtl/elc_band.sv -----
`timescale 1ns / 1ps
module elc_band (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [elc_pkg::ELEV_W-1:0] elev,
  output logic                              out_valid,
  input  logic                              out_ready,
  output elc_pkg::sel_t                     out_sel
);
  import elc_pkg::*;

  band_t                    band;
  band_const_t              c;
  logic signed [ELEV_W:0]   diff;
  sel_t                     sel_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    band     = band_of(elev);
    c        = band_const(band);
    diff     = {elev[ELEV_W-1], elev} - {c.lo[ELEV_W-1], c.lo};
    sel_next = '{band: band, x: diff[X_W-1:0]};
    if (band == BAND_NIGHT || band == BAND_TOP) sel_next.x = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (in_ready) out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) out_sel <= sel_next;
  end

endmodule

// ----- rtl/elc_map.sv -----
`timescale 1ns / 1ps
module elc_map (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  elc_pkg::sel_t   in_sel,
  output logic            out_valid,
  input  logic            out_ready,
  output elc_pkg::light_t out_light
);
  import elc_pkg::*;

  logic            prod_valid;
  logic            prod_ready;
  prod_t           prod;
  logic            quot_valid;
  logic            quot_ready;
  quot_t           quot;
  band_const_t     cp;
  band_const_t     cq;
  band_const_t     cr;
  prod_t           prod_next;
  logic [MK_W-1:0] mk;
  logic [MB_W-1:0] mb;
  quot_t           quot_next;
  logic [NK_W-1:0] rk;
  logic [NB_W-1:0] rb;
  logic [QK_W-1:0] qk_fix;
  logic [QB_W-1:0] qb_fix;
  light_t          light_next;

  assign quot_ready = !out_valid || out_ready;
  assign prod_ready = !quot_valid || quot_ready;
  assign in_ready   = !prod_valid || prod_ready;

  // span products
  always_comb begin
    cp        = band_const(in_sel.band);
    prod_next = '{band: in_sel.band,
                  nk:   NK_W'(in_sel.x) * NK_W'(cp.kspan),
                  nb:   NB_W'(in_sel.x) * NB_W'(cp.bspan)};
  end

  // quotient estimate by reciprocal
  always_comb begin
    cq        = band_const(prod.band);
    mk        = MK_W'(prod.nk) * MK_W'(cq.recip);
    mb        = MB_W'(prod.nb) * MB_W'(cq.recip);
    quot_next = '{band: prod.band, nk: prod.nk, nb: prod.nb,
                  qk: mk[RECIP_SH +: QK_W], qb: mb[RECIP_SH +: QB_W]};
  end

  // correct estimate by one, add band base
  always_comb begin
    cr     = band_const(quot.band);
    rk     = quot.nk - NK_W'(quot.qk) * NK_W'(cr.div);
    rb     = quot.nb - NB_W'(quot.qb) * NB_W'(cr.div);
    qk_fix = quot.qk + QK_W'(rk >= NK_W'(cr.div));
    qb_fix = quot.qb + QB_W'(rb >= NB_W'(cr.div));
    light_next = '{night:      quot.band == BAND_NIGHT,
                   kelvin:     cr.kbase + KELV_W'(qk_fix),
                   brightness: cr.bbase + LVL_W'(qb_fix)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      quot_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready)   prod_valid <= in_valid;
      if (prod_ready) quot_valid <= prod_valid;
      if (quot_ready) out_valid  <= quot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready)     prod      <= prod_next;
    if (prod_valid && prod_ready) quot      <= quot_next;
    if (quot_valid && quot_ready) out_light <= light_next;
  end

endmodule

// ----- rtl/elc_rom.sv -----
`timescale 1ns / 1ps
module elc_rom (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  elc_pkg::light_t in_light,
  output logic            out_valid,
  input  logic            out_ready,
  output elc_pkg::color_t out_color
);
  import elc_pkg::*;

  localparam rom_t COLOR_ROM = build_rom();

  light_t                held;
  rom_word_t             rom_q;
  logic [KELV_W-1:0]     koff;
  logic [ROM_IDX_W-1:0]  idx;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    koff = in_light.kelvin - KELV_MIN;
    idx  = in_light.night ? '0 : koff[ROM_IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (in_ready) out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rom_q <= COLOR_ROM[idx];
      held  <= in_light;
    end
  end

  always_comb begin
    out_color.red          = held.night ? '0 : LVL_FULL;
    out_color.green        = held.night ? '0 : rom_q[2*LVL_W-1:LVL_W];
    out_color.blue         = held.night ? '0 : rom_q[LVL_W-1:0];
    out_color.brightness   = held.night ? '0 : held.brightness;
    out_color.color_kelvin = held.night ? '0 : held.kelvin;
  end

endmodule

// ----- rtl/elevation_to_light_color_top.sv -----
`timescale 1ns / 1ps
// Sun elevation to light color. Each input word carries one elevation in
// tenths of a degree; each output word carries red, green, blue, brightness
// and color temperature in kelvin. The block takes one word per clock while
// the output is not stalled; each word passes band decode, span multiply,
// reciprocal multiply, quotient correction, then a registered read of a
// 5001-entry constant color ROM indexed by kelvin minus 1500, which is
// built at elaboration and needs no clearing pass after reset. Backpressure
// on the output stalls the pipeline stage by stage without dropping a word.
module elevation_to_light_color_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [10:0] elevation_tenths
  input  logic [elc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] brightness,
  // [44:32] color_kelvin
  output logic [elc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import elc_pkg::*;

  logic   sel_valid;
  logic   sel_ready;
  sel_t   sel;
  logic   light_valid;
  logic   light_ready;
  light_t light;
  color_t color;

  elc_band u_band (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .elev      ($signed(s_axis_tdata[ELEV_W-1:0])),
    .out_valid (sel_valid),
    .out_ready (sel_ready),
    .out_sel   (sel)
  );

  elc_map u_map (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sel_valid),
    .in_ready  (sel_ready),
    .in_sel    (sel),
    .out_valid (light_valid),
    .out_ready (light_ready),
    .out_light (light)
  );

  elc_rom u_rom (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (light_valid),
    .in_ready  (light_ready),
    .in_light  (light),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_color (color)
  );

  assign m_axis_tdata = OUT_TDATA_W'(color);

  `include "elevation_to_light_color_top_assert.svh"

  `ELC_ASSERT_NXT(a_light_hold, light_valid && !light_ready, light_valid && $stable(light))
  `ELC_ASSERT_IMP(a_night_dark, m_axis_tvalid && color.red == '0, color.color_kelvin == '0 && color.green == '0 && color.blue == '0 && color.brightness == '0)
  `ELC_ASSERT_IMP(a_kelvin_range, m_axis_tvalid && color.red != '0, color.color_kelvin >= KELV_MIN && color.color_kelvin <= KELV_MAX)
  `ELC_ASSERT_IMP(a_blue_cut, m_axis_tvalid && color.color_kelvin <= KELV_BLUE_MIN, color.blue == '0)

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import elc_pkg::*;

  localparam int RANDOM_WORDS  = 1950;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int IDLE_PCT      = 35;
  localparam int BURST_FIRST   = 600;
  localparam int BURST_LAST    = 899;

  class color_scoreboard;
    localparam logic [63:0] Q24_UNIT   = 64'd16777216;
    localparam logic [63:0] DEC_UNIT   = 64'd10000000000;
    localparam logic [63:0] GRN_SLOPE  = 64'd99 * Q24_UNIT + (64'd4708025861 * Q24_UNIT) / DEC_UNIT;
    localparam logic [63:0] GRN_OFFSET = 64'd161 * Q24_UNIT + (64'd1195681661 * Q24_UNIT) / DEC_UNIT;
    localparam logic [63:0] BLU_SLOPE  = 64'd138 * Q24_UNIT + (64'd5177312231 * Q24_UNIT) / DEC_UNIT;
    localparam logic [63:0] BLU_OFFSET = 64'd305 * Q24_UNIT + (64'd447927307 * Q24_UNIT) / DEC_UNIT;

    color_t      expected_colors[$];
    int          mismatches;
    int          words_checked;
    int          night_words;
    int          blue_words;
    logic [63:0] ln2_q30;
    logic [63:0] ln100_q30;

    function new();
      mismatches    = 0;
      words_checked = 0;
      night_words   = 0;
      blue_words    = 0;
      ln2_q30       = 64'd2 * atanh_sum((64'd1 << 30) / 64'd3);
      ln100_q30     = ln_fix(32'd100);
    endfunction

    function logic [63:0] atanh_sum(logic [63:0] z);
      logic [63:0] acc;
      logic [63:0] term;
      logic [63:0] zsq;
      acc  = z;
      term = z;
      zsq  = (z * z) >> 30;
      for (int k = 3; k < 99; k += 2) begin
        term = (term * zsq) >> 30;
        if (term == 64'd0) break;
        acc = acc + term / 64'(k);
      end
      return acc;
    endfunction

    function logic [63:0] ln_fix(logic [31:0] x);
      int          msb;
      logic [63:0] base;
      logic [63:0] z;
      if (x == 32'd0) return 64'd0;
      msb = 0;
      for (int i = 0; i < 32; i++) begin
        if (x[i]) msb = i;
      end
      base = 64'd1 << msb;
      z    = ((64'(x) - base) << 30) / (64'(x) + base);
      return 64'(msb) * ln2_q30 + 64'd2 * atanh_sum(z);
    endfunction

    function logic [LVL_W-1:0] curve_level(logic [63:0] slope, logic [63:0] offset,
                                           logic [31:0] num);
      logic [63:0] ln_num;
      logic [63:0] ln_ratio;
      logic [63:0] scaled;
      logic [63:0] level;
      ln_num   = ln_fix(num);
      ln_ratio = (ln_num > ln100_q30) ? ln_num - ln100_q30 : 64'd0;
      scaled   = (slope * ln_ratio) >> 30;
      if (scaled <= offset) return '0;
      level = (scaled - offset) >> 24;
      return (level > 64'd255) ? 8'd255 : level[LVL_W-1:0];
    endfunction

    function int lerp(int x, int a, int b, int c, int d);
      return (x - a) * (d - c) / (b - a) + c;
    endfunction

    function color_t predict_color(logic signed [ELEV_W-1:0] elev);
      color_t res;
      int     t;
      int     kel;
      int     bri;
      t   = int'(elev);
      res = '0;
      if (t < -180) return res;
      if (t < -120) begin
        kel = 1500;
        bri = lerp(t, -180, -120, 0, 40);
      end else if (t < -60) begin
        kel = lerp(t, -120, -60, 1500, 2000);
        bri = lerp(t, -120, -60, 40, 80);
      end else if (t < -8) begin
        kel = lerp(t, -60, -8, 2000, 2800);
        bri = lerp(t, -60, -8, 80, 140);
      end else if (t < 60) begin
        kel = lerp(t, -8, 60, 2800, 3800);
        bri = lerp(t, -8, 60, 140, 200);
      end else if (t < 150) begin
        kel = lerp(t, 60, 150, 3800, 4800);
        bri = lerp(t, 60, 150, 200, 230);
      end else if (t < 300) begin
        kel = lerp(t, 150, 300, 4800, 5500);
        bri = lerp(t, 150, 300, 230, 250);
      end else if (t < 500) begin
        kel = lerp(t, 300, 500, 5500, 5900);
        bri = 255;
      end else begin
        kel = 6500;
        bri = 255;
      end
      res.red          = 8'd255;
      res.green        = curve_level(GRN_SLOPE, GRN_OFFSET, 32'(kel));
      res.blue         = (kel <= 1900) ? 8'd0 : curve_level(BLU_SLOPE, BLU_OFFSET, 32'(kel - 1000));
      res.brightness   = bri[LVL_W-1:0];
      res.color_kelvin = kel[KELV_W-1:0];
      return res;
    endfunction

    function void note_elevation(logic signed [ELEV_W-1:0] elev);
      expected_colors.push_back(predict_color(elev));
    endfunction

    function void check_color(color_t got);
      color_t want;
      if (expected_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected word r=%0d g=%0d b=%0d br=%0d k=%0d",
                   got.red, got.green, got.blue, got.brightness, got.color_kelvin);
        return;
      end
      want = expected_colors.pop_front();
      words_checked++;
      if (want.color_kelvin == '0) night_words++;
      if (want.blue != '0) blue_words++;
      if (got.red != want.red || got.green != want.green || got.blue != want.blue ||
          got.brightness != want.brightness || got.color_kelvin != want.color_kelvin) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: word %0d exp r=%0d g=%0d b=%0d br=%0d k=%0d, got r=%0d g=%0d b=%0d br=%0d k=%0d",
                   words_checked, want.red, want.green, want.blue, want.brightness,
                   want.color_kelvin, got.red, got.green, got.blue, got.brightness,
                   got.color_kelvin);
      end
    endfunction

    function int pending();
      return expected_colors.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  color_scoreboard sb = new();
  logic            no_idle = 1'b0;
  int              cycles = 0;
  int              words_sent = 0;

  elevation_to_light_color_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("elevation_to_light_color_top test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) sb.note_elevation(s_axis_tdata[ELEV_W-1:0]);
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_color(color_t'(m_axis_tdata[44:0]));
  end

  task automatic send_elevation(input logic signed [ELEV_W-1:0] elev);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W-ELEV_W){1'b0}}, elev};
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
  endtask

  task automatic send_random_elevation();
    int pick;
    int val;
    pick = $urandom_range(99);
    if (pick < 80)      val = int'($urandom_range(720)) - 200;
    else if (pick < 95) val = int'($urandom_range(1800)) - 900;
    else                val = int'($urandom_range(2047));
    send_elevation(val[ELEV_W-1:0]);
  endtask

  initial begin
    int corners[$];
    corners = '{-1024, 1023, -900, 900, -181, -180, -179, -121, -120, -72, -71,
                -61, -60, -9, -8, -7, 59, 60, 149, 150, 299, 300, 499, 500, 0};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (corners[i]) send_elevation(corners[i][ELEV_W-1:0]);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      no_idle = (n >= BURST_FIRST && n <= BURST_LAST);
      send_random_elevation();
    end
    no_idle = 1'b0;
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d elevation words, checked %0d color words", words_sent,
             sb.words_checked);
    $display("Deep night words: %0d, words with blue: %0d, mismatches: %0d",
             sb.night_words, sb.blue_words, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("elevation_to_light_color_top test passed");
    end else begin
      $display("elevation_to_light_color_top test failed");
    end
    $finish;
  end

endmodule
